### rtl/rlc_pkg.sv
// ----------------------------------------------------------------------------
// Route loop compressor package
// Hop word layout and field widths shared by the store and the controller.
// ----------------------------------------------------------------------------
package rlc_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned HOP_W  = ADDR_W + KIND_W;

  // One stored hop: kind in the upper bits, address below
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
  } hop_t;

endpackage

### rtl/rlc_hop_ram.sv
// ----------------------------------------------------------------------------
// Route loop compressor hop store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module rlc_hop_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  rlc_pkg::hop_t     wr_data_i,
  input  logic              rd_en_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output rlc_pkg::hop_t     rd_data_o
);

  rlc_pkg::hop_t mem_q [Depth];
  rlc_pkg::hop_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held until the next enabled read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/route_loop_compressor.sv
// ----------------------------------------------------------------------------
// Route loop compressor
// Collects a source route, removes every double back, emits the result.
// ----------------------------------------------------------------------------
// Hops are taken one per cycle while loading; a hop that arrives with the
// store full is dropped and sets the overflow flag on every output word of
// that route. The marked last hop starts compression, during which the input
// is not ready: for each forward position the backward position scans down
// from the last hop, and at the first equal hop (address and kind) the span in
// between is cut and the tail moved down. All work runs through the single
// read port of the hop store and one 34-bit comparator: each forward hop is
// read and latched, each backward hop is read and then compared, and each
// hop moved is read and then written. Emission then reads one output word
// at a time and waits while the output stalls. Loading of the next route
// starts while the last word still waits.
module route_loop_compressor #(
  parameter int unsigned MAX_HOPS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [rlc_pkg::ADDR_W-1:0] hop_addr_i,
  input  logic [rlc_pkg::KIND_W-1:0] hop_kind_i,
  input  logic                       last_hop_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rlc_pkg::ADDR_W-1:0] out_addr_o,
  output logic [rlc_pkg::KIND_W-1:0] out_kind_o,
  output logic                       out_last_o,
  output logic                       overflow_o
);

  localparam int unsigned IdxW = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
  localparam int unsigned CntW = $clog2(MAX_HOPS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_HOPS);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FWD_RD,
    ST_FWD_LATCH,
    ST_BACK_RD,
    ST_CMP,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } state_e;

  state_e              state_q;
  logic [CntW-1:0]     len_q;
  logic                ovf_q;
  logic [CntW-1:0]     fwd_q;
  logic [IdxW-1:0]     back_q;
  logic [CntW-1:0]     src_q;
  logic [CntW-1:0]     dst_q;
  logic [CntW-1:0]     k_q;
  rlc_pkg::hop_t       fwd_hop_q;
  logic                out_valid_q;
  rlc_pkg::hop_t       out_hop_q;
  logic                out_last_q;
  logic                out_ovf_q;

  logic                in_fire;
  logic                store_full;
  logic                wr_en;
  logic [IdxW-1:0]     wr_addr;
  rlc_pkg::hop_t       wr_data;
  rlc_pkg::hop_t       in_hop;
  logic                rd_en;
  logic [IdxW-1:0]     rd_addr;
  rlc_pkg::hop_t       rd_data;
  logic                hop_match;
  logic                out_free;
  logic                out_load;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire    = in_valid_i & in_ready_o;
  assign store_full = (len_q == CntMax);
  assign in_hop     = '{kind: hop_kind_i, addr: hop_addr_i};
  assign out_free   = ~out_valid_q | out_ready_i;
  // next output word goes into the output register
  assign out_load   = (state_q == ST_EMIT_WAIT) & out_free;

  // single comparator: stored hop against the held forward hop
  assign hop_match = (rd_data == fwd_hop_q);

  // store write: incoming hop while loading, tail move while compressing
  always_comb begin
    if (state_q == ST_MOVE_WR) begin
      wr_en   = 1'b1;
      wr_addr = dst_q[IdxW-1:0];
      wr_data = rd_data;
    end else begin
      wr_en   = in_fire & ~store_full;
      wr_addr = len_q[IdxW-1:0];
      wr_data = in_hop;
    end
  end

  // store read address select
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = k_q[IdxW-1:0];
    unique case (state_q)
      ST_FWD_RD: begin
        rd_en   = (fwd_q < len_q);
        rd_addr = fwd_q[IdxW-1:0];
      end
      ST_BACK_RD: begin
        rd_en   = (CntW'(back_q) != fwd_q);
        rd_addr = back_q;
      end
      ST_MOVE_RD: begin
        rd_en   = (src_q < len_q);
        rd_addr = src_q[IdxW-1:0];
      end
      ST_EMIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = k_q[IdxW-1:0];
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = k_q[IdxW-1:0];
      end
    endcase
  end

  rlc_hop_ram #(
    .Depth (MAX_HOPS),
    .AddrW (IdxW)
  ) u_hop_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // sequencer, counters and output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      fwd_q       <= '0;
      back_q      <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      k_q         <= '0;
      fwd_hop_q   <= '0;
      out_valid_q <= 1'b0;
      out_hop_q   <= '0;
      out_last_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (in_fire) begin
            if (store_full) begin
              ovf_q <= 1'b1;
            end else begin
              len_q <= len_q + CntOne;
            end
            if (last_hop_i) begin
              fwd_q   <= '0;
              state_q <= ST_FWD_RD;
            end
          end
        end
        ST_FWD_RD: begin
          if (fwd_q < len_q) begin
            back_q  <= IdxW'(len_q - CntOne);
            state_q <= ST_FWD_LATCH;
          end else begin
            k_q     <= '0;
            state_q <= ST_EMIT_RD;
          end
        end
        ST_FWD_LATCH: begin
          fwd_hop_q <= rd_data;
          state_q   <= ST_BACK_RD;
        end
        ST_BACK_RD: begin
          // scan reached the forward position: no loop from this hop
          if (CntW'(back_q) == fwd_q) begin
            fwd_q   <= fwd_q + CntOne;
            state_q <= ST_FWD_RD;
          end else begin
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (hop_match) begin
            src_q   <= CntW'(back_q);
            dst_q   <= fwd_q;
            state_q <= ST_MOVE_RD;
          end else begin
            back_q  <= back_q - IdxW'(1);
            state_q <= ST_BACK_RD;
          end
        end
        ST_MOVE_RD: begin
          if (src_q < len_q) begin
            state_q <= ST_MOVE_WR;
          end else begin
            len_q   <= dst_q;
            fwd_q   <= fwd_q + CntOne;
            state_q <= ST_FWD_RD;
          end
        end
        ST_MOVE_WR: begin
          src_q   <= src_q + CntOne;
          dst_q   <= dst_q + CntOne;
          state_q <= ST_MOVE_RD;
        end
        ST_EMIT_RD: begin
          state_q <= ST_EMIT_WAIT;
        end
        ST_EMIT_WAIT: begin
          if (out_free) begin
            out_hop_q   <= rd_data;
            out_ovf_q   <= ovf_q;
            out_last_q  <= ((k_q + CntOne) == len_q);
            if ((k_q + CntOne) == len_q) begin
              len_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= ST_LOAD;
            end else begin
              k_q     <= k_q + CntOne;
              state_q <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_addr_o  = out_hop_q.addr;
  assign out_kind_o  = out_hop_q.kind;
  assign out_last_o  = out_last_q;
  assign overflow_o  = out_ovf_q;

endmodule
